[design/sli_pkg.sv]
package sli_pkg;

  localparam int CAPACITY_DEF = 64;

  // field widths of the words on the ports
  localparam int ACT_W  = 2;
  localparam int KEY_W  = 32;
  localparam int POS_W  = 7;
  localparam int ST_W   = 2;
  localparam int FIDX_W = 6;
  localparam int ECNT_W = 7;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LINEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BINARY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_POS  = 2'd2;

  // per-cell write control
  typedef struct packed {
    logic load_key;   // cell is the insert slot
    logic take_left;  // cell takes its lower neighbour's entry
  } cell_ctl_t;

endpackage

[design/sli_cell.sv]
module sli_cell import sli_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [KEY_W-1:0] left_entry,
  output logic signed [KEY_W-1:0] entry,
  output logic                    eq,
  output logic                    lt
);

  logic signed [KEY_W-1:0] entry_r;
  logic                    eq_r;
  logic                    lt_r;

  always_ff @(posedge clk) begin
    if (ctl.load_key) begin
      entry_r <= key;
    end else if (ctl.take_left) begin
      entry_r <= left_entry;
    end
    eq_r <= (entry_r == key);
    lt_r <= (entry_r < key);
  end

  assign entry = entry_r;
  assign eq    = eq_r;
  assign lt    = lt_r;

endmodule

[design/sli_tree.sv]
module sli_tree import sli_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic                     clk,
  input  logic [(1<<IDX_W)-1:0]    leaf_hit,
  output logic                     root_hit,
  output logic [IDX_W-1:0]         root_idx
);

  localparam int NP2 = 1 << IDX_W;

  logic [NP2-1:0]   lvl_hit [IDX_W+1];
  logic [IDX_W-1:0] lvl_idx [IDX_W+1][NP2];

  assign lvl_hit[0] = leaf_hit;

  for (genvar j = 0; j < NP2; j++) begin : g_leaf
    assign lvl_idx[0][j] = '0;
  end

  // one registered level per index bit; the lower half wins a tie
  for (genvar l = 1; l <= IDX_W; l++) begin : g_lvl
    localparam int NN = NP2 >> l;
    logic [NN-1:0]    hit_r;
    logic [IDX_W-1:0] idx_r [NN];

    always_ff @(posedge clk) begin
      for (int j = 0; j < NN; j++) begin
        hit_r[j] <= lvl_hit[l-1][2*j] | lvl_hit[l-1][2*j+1];
        idx_r[j] <= lvl_hit[l-1][2*j] ? lvl_idx[l-1][2*j]
                  : (lvl_idx[l-1][2*j+1] | IDX_W'(1 << (l-1)));
      end
    end

    assign lvl_hit[l] = NP2'(hit_r);

    for (genvar j = 0; j < NP2; j++) begin : g_node
      if (j < NN) begin : g_used
        assign lvl_idx[l][j] = idx_r[j];
      end else begin : g_pad
        assign lvl_idx[l][j] = '0;
      end
    end
  end

  assign root_hit = lvl_hit[IDX_W][0];
  assign root_idx = lvl_idx[IDX_W][0];

endmodule

[design/sequential_list_insert_search.sv]
// Channel   Ports                                         Handshake
// --------  --------------------------------------------  --------------------------------
// input     in_action, in_key_value, in_position          word taken when start & !busy
// result    out_status, out_found, out_found_index,       out_valid high for one cycle,
//           out_entry_count                               taken at the closing edge
//
// Steps from accept to strobe: an insert is done in S_EXEC; a linear find latches the cell
// flags in S_EXEC, then the first match climbs the tree in S_TREE; a binary find latches the
// flags, then probes them in S_BIN (one probe of the cell flags per cycle).
// busy drops in the strobe cycle, so a new word may be taken while the result shows.
// Reset (rst_n low, synchronous) empties the list; cell contents are left as they are.
// The receiver cannot stall; every accepted word gives exactly one strobe.
module sequential_list_insert_search import sli_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ACT_W-1:0]        in_action,
  input  logic signed [KEY_W-1:0] in_key_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    busy,
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic                    out_found,
  output logic [FIDX_W-1:0]       out_found_index,
  output logic [ECNT_W-1:0]       out_entry_count
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int NP2    = 1 << IDX_W;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int STEP_W = $clog2(IDX_W + 1);

  // sequencer
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a word
  localparam logic [1:0] S_EXEC = 2'd1;  // insert, or cells latch their compare flags
  localparam logic [1:0] S_TREE = 2'd2;  // linear find: first match climbs the tree
  localparam logic [1:0] S_BIN  = 2'd3;  // binary find: one probe a cycle

  logic [1:0]              state_r,  state_nxt;
  logic [ACT_W-1:0]        action_r, action_nxt;
  logic signed [KEY_W-1:0] key_r,    key_nxt;
  logic [POS_W-1:0]        pos_r,    pos_nxt;
  logic [CNT_W-1:0]        count_r,  count_nxt;
  logic [STEP_W-1:0]       step_r,   step_nxt;
  logic [CNT_W-1:0]        lo_r,     lo_nxt;    // binary range, lower bound
  logic [CNT_W-1:0]        hi_r,     hi_nxt;    // binary range, exclusive upper bound
  logic                    ovld_r,   ovld_nxt;
  logic [ST_W-1:0]         ost_r,    ost_nxt;
  logic                    ofnd_r,   ofnd_nxt;
  logic [FIDX_W-1:0]       oidx_r,   oidx_nxt;
  logic [ECNT_W-1:0]       ocnt_r,   ocnt_nxt;

  // insert checks; full is tested before the position
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             list_full;
  logic             pos_bad;
  logic             ins_go;

  assign pos_ext   = CMP_W'(pos_r);
  assign cnt_ext   = CMP_W'(count_r);
  assign list_full = (count_r == CNT_W'(CAPACITY));
  assign pos_bad   = (pos_ext > cnt_ext);
  assign ins_go    = (state_r == S_EXEC) && (action_r == ACT_INSERT) && !list_full && !pos_bad;

  // ---------------------------------------------------------------
  // Cell chain: one entry per cell. On insert, cells above the slot
  // take their lower neighbour's entry and the slot takes the key, all
  // at the same clock edge. Every cell compares its entry with the key each cycle.
  // ---------------------------------------------------------------
  logic signed [KEY_W-1:0] cell_entry [CAPACITY];
  logic [NP2-1:0]          cell_eq;
  logic [NP2-1:0]          cell_lt;
  logic [NP2-1:0]          used;

  for (genvar i = 0; i < NP2; i++) begin : g_cell
    if (i < CAPACITY) begin : g_live
      cell_ctl_t               ctl;
      logic signed [KEY_W-1:0] left;

      assign ctl.load_key  = ins_go && (CMP_W'(i) == pos_ext);
      assign ctl.take_left = ins_go && (CMP_W'(i) > pos_ext) && (CMP_W'(i) <= cnt_ext);
      assign used[i]       = (CNT_W'(i) < count_r);

      if (i == 0) begin : g_first
        assign left = key_r;
      end else begin : g_rest
        assign left = cell_entry[i-1];
      end

      sli_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .key        (key_r),
        .left_entry (left),
        .entry      (cell_entry[i]),
        .eq         (cell_eq[i]),
        .lt         (cell_lt[i])
      );
    end else begin : g_pad
      assign cell_eq[i] = 1'b0;
      assign cell_lt[i] = 1'b0;
      assign used[i]    = 1'b0;
    end
  end

  // first match among entries in use
  logic             root_hit;
  logic [IDX_W-1:0] root_idx;

  sli_tree #(
    .IDX_W (IDX_W)
  ) u_tree (
    .clk      (clk),
    .leaf_hit (cell_eq & used),
    .root_hit (root_hit),
    .root_idx (root_idx)
  );

  // binary probe: mid = (lo + hi_incl) / 2 with hi_incl = hi - 1
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid_full;
  logic [IDX_W-1:0] mid;
  logic             probe_eq;
  logic             probe_lt;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W+1)'(1);
  assign mid_full = mid_sum[CNT_W:1];
  assign mid      = IDX_W'(mid_full);
  assign probe_eq = cell_eq[mid];
  assign probe_lt = cell_lt[mid];

  always_comb begin
    state_nxt  = state_r;
    action_nxt = action_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    step_nxt   = step_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    ovld_nxt   = 1'b0;
    ost_nxt    = ost_r;
    ofnd_nxt   = ofnd_r;
    oidx_nxt   = oidx_r;
    ocnt_nxt   = ocnt_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          action_nxt = in_action;
          key_nxt    = in_key_value;
          pos_nxt    = in_position;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        step_nxt = '0;
        lo_nxt   = '0;
        hi_nxt   = count_r;
        case (action_r)
          ACT_INSERT: begin
            ovld_nxt  = 1'b1;
            ofnd_nxt  = 1'b0;
            oidx_nxt  = '0;
            state_nxt = S_IDLE;
            if (list_full) begin
              ost_nxt = ST_FULL;
            end else if (pos_bad) begin
              ost_nxt = ST_POS;
            end else begin
              ost_nxt   = ST_OK;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          ACT_LINEAR: begin
            state_nxt = S_TREE;
          end
          ACT_BINARY: begin
            state_nxt = S_BIN;
          end
          default: begin
            ovld_nxt  = 1'b1;
            ost_nxt   = ST_OK;
            ofnd_nxt  = 1'b0;
            oidx_nxt  = '0;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_TREE: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(IDX_W)) begin
          ovld_nxt  = 1'b1;
          ost_nxt   = ST_OK;
          ofnd_nxt  = root_hit;
          oidx_nxt  = root_hit ? FIDX_W'(root_idx) : '0;
          state_nxt = S_IDLE;
        end
      end
      S_BIN: begin
        if (lo_r >= hi_r) begin
          ovld_nxt  = 1'b1;
          ost_nxt   = ST_OK;
          ofnd_nxt  = 1'b0;
          oidx_nxt  = '0;
          state_nxt = S_IDLE;
        end else if (probe_eq) begin
          ovld_nxt  = 1'b1;
          ost_nxt   = ST_OK;
          ofnd_nxt  = 1'b1;
          oidx_nxt  = FIDX_W'(mid);
          state_nxt = S_IDLE;
        end else if (probe_lt) begin
          lo_nxt = mid_full + CNT_W'(1);
        end else begin
          hi_nxt = mid_full;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ovld_nxt) begin
      ocnt_nxt = ECNT_W'(count_nxt);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    key_r    <= key_nxt;
    pos_r    <= pos_nxt;
    step_r   <= step_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    ost_r    <= ost_nxt;
    ofnd_r   <= ofnd_nxt;
    oidx_r   <= oidx_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ovld_r;
  assign out_status      = ost_r;
  assign out_found       = ofnd_r;
  assign out_found_index = oidx_r;
  assign out_entry_count = ocnt_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      (count_r == CNT_W'($past(count_r) + CNT_W'(1))))
    else $error("entry count moved by other than one");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_OK))
    else $error("hit reported with bad status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_found_index == '0))
    else $error("miss with nonzero index");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not occupy the block");

endmodule
